### hw/rtl/semb_pkg.sv
package semb_pkg;

	// Bank geometry
	localparam int NUM_SEMS   = 16;
	localparam int COUNT_BITS = 16;
	localparam int IDX_W      = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;

	// Free scan looks at a group of flags per cycle
	localparam int GROUP      = 4;
	localparam int LANE_W     = $clog2(GROUP);
	localparam int NUM_GROUPS = (NUM_SEMS + GROUP - 1) / GROUP;
	localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

	// Command codes
	localparam logic [2:0] CMD_OPEN  = 3'd0;
	localparam logic [2:0] CMD_CLOSE = 3'd1;
	localparam logic [2:0] CMD_UP    = 3'd2;
	localparam logic [2:0] CMD_DOWN  = 3'd3;
	localparam logic [2:0] CMD_FIND  = 3'd4;

	// Status codes
	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_BLOCK  = 2'd2;

	typedef logic [COUNT_BITS-1:0] cnt_t;
	typedef logic [IDX_W-1:0]      sem_idx_t;
	typedef logic [15:0]           cnt16_t;
	typedef logic [3:0]            free_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [3:0]  sem_index;
		logic [15:0] init_value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        wake;
		logic [15:0] count_after;
		logic [3:0]  free_index;
	} rsp_t;

	typedef struct packed {
		cnt_t sum;
		logic carry;
		logic a_zero;
	} alu_res_t;

endpackage

### hw/rtl/semb_alu.sv
module semb_alu (
	input  semb_pkg::cnt_t     a,
	input  logic               sub,
	output semb_pkg::alu_res_t res
);
	import semb_pkg::*;

	logic [COUNT_BITS:0] sum_w;

	// add one, or add all ones to step down by one
	assign sum_w = {1'b0, a} + (sub ? {1'b0, {COUNT_BITS{1'b1}}} : (COUNT_BITS + 1)'(1));

	assign res.sum    = sum_w[COUNT_BITS-1:0];
	assign res.carry  = sum_w[COUNT_BITS];
	assign res.a_zero = (a == '0);

endmodule

### hw/rtl/counting_semaphore_bank_top.sv
// Counting semaphore bank, one result word per command word.
// Open, close, up, down: busy through S_READ and S_EXEC after the start edge,
// done strobes on the return to idle; a new word is taken in the done cycle.
// Find free: scans GROUP open flags per cycle, busy until a hit or the last group.
// The receiver cannot stall: done is a one-cycle strobe with rsp valid.
// Reset (arst_n low, async) zeroes every count and closes every entry.
module counting_semaphore_bank_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  semb_pkg::cmd_t cmd,
	output logic           done,
	output semb_pkg::rsp_t rsp
);
	import semb_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_EXEC = 4'b0100,
		S_SCAN = 4'b1000
	} state_t;

	state_t   state_q;
	cmd_t     cmd_q;
	cnt_t     c_q;
	logic     done_q;
	rsp_t     rsp_q;
	logic [GRP_W-1:0] grp_q;

	// Semaphore state: small enough to live in flops cleared by reset
	cnt_t     counts_q [NUM_SEMS];
	logic [NUM_SEMS-1:0] open_q;

	// Decoded view of the held command word
	logic     idx_ok;
	sem_idx_t sel;
	logic     val_too_big;
	logic     sel_open;

	assign idx_ok      = (int'(cmd_q.sem_index) < NUM_SEMS);
	assign sel         = sem_idx_t'(cmd_q.sem_index);
	assign val_too_big = ((64'(cmd_q.init_value) >> COUNT_BITS) != 64'd0);
	assign sel_open    = idx_ok ? open_q[sel] : 1'b0;

	// Shared adder: steps the fetched count up or down
	alu_res_t alu;

	semb_alu u_alu (
		.a   (c_q),
		.sub (cmd_q.command == CMD_DOWN),
		.res (alu)
	);

	// Execute step: decide the write back and the result word
	logic wr_cnt;
	cnt_t wr_val;
	logic set_open;
	logic clr_open;
	rsp_t ex_rsp;

	always_comb begin
		wr_cnt   = 1'b0;
		wr_val   = alu.sum;
		set_open = 1'b0;
		clr_open = 1'b0;
		ex_rsp   = '0;
		ex_rsp.count_after = cnt16_t'(c_q);
		if (!idx_ok) begin
			ex_rsp.status      = ST_REJECT;
			ex_rsp.count_after = '0;
		end else begin
			case (cmd_q.command)
				CMD_OPEN: begin
					if (sel_open || val_too_big) begin
						ex_rsp.status = ST_REJECT;
					end else begin
						wr_cnt             = 1'b1;
						wr_val             = cnt_t'(cmd_q.init_value);
						set_open           = 1'b1;
						ex_rsp.status      = ST_DONE;
						ex_rsp.count_after = cmd_q.init_value;
					end
				end
				CMD_CLOSE: begin
					clr_open      = 1'b1;
					ex_rsp.status = ST_DONE;
				end
				CMD_UP: begin
					// carry out means the count already sits at its maximum
					if (alu.carry) begin
						ex_rsp.status = ST_REJECT;
					end else begin
						wr_cnt             = 1'b1;
						ex_rsp.status      = ST_DONE;
						ex_rsp.wake        = alu.a_zero;
						ex_rsp.count_after = cnt16_t'(alu.sum);
					end
				end
				CMD_DOWN: begin
					if (alu.a_zero) begin
						ex_rsp.status      = ST_BLOCK;
						ex_rsp.count_after = '0;
					end else begin
						wr_cnt             = 1'b1;
						ex_rsp.status      = ST_DONE;
						ex_rsp.count_after = cnt16_t'(alu.sum);
					end
				end
				default: begin
					ex_rsp.status = ST_REJECT;
				end
			endcase
		end
	end

	// Free scan: one group of closed flags per cycle, lowest lane wins
	logic [NUM_GROUPS*GROUP-1:0] closed_pad;
	logic [GROUP-1:0]            grp_bits;
	logic                        hit;
	logic [LANE_W-1:0]           lane;
	logic                        last_grp;
	rsp_t                        scan_rsp;

	always_comb begin
		closed_pad               = '0;
		closed_pad[NUM_SEMS-1:0] = ~open_q;
	end

	assign grp_bits = closed_pad[grp_q*GROUP +: GROUP];
	assign hit      = |grp_bits;
	assign last_grp = (grp_q == GRP_W'(NUM_GROUPS - 1));

	always_comb begin
		lane = '0;
		for (int l = GROUP - 1; l >= 0; l--) begin
			if (grp_bits[l]) begin
				lane = LANE_W'(l);
			end
		end
	end

	always_comb begin
		scan_rsp = '0;
		if (hit) begin
			scan_rsp.status     = ST_DONE;
			scan_rsp.free_index = free_t'({grp_q, lane});
		end else begin
			scan_rsp.status     = ST_REJECT;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			grp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						grp_q <= '0;
						if (cmd.command == CMD_FIND) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (hit || last_grp) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						grp_q <= grp_q + GRP_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Semaphore state updates land at the end of the execute step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SEMS; i++) begin
				counts_q[i] <= '0;
			end
			open_q <= '0;
		end else if (state_q == S_EXEC && idx_ok) begin
			if (wr_cnt) begin
				counts_q[sel] <= wr_val;
			end
			if (set_open) begin
				open_q[sel] <= 1'b1;
			end
			if (clr_open) begin
				open_q[sel] <= 1'b0;
			end
		end
	end

	// Payload: hold the command word, fetch the count, register the result
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q <= cmd;
		end
		if (state_q == S_READ) begin
			c_q <= idx_ok ? counts_q[sel] : '0;
		end
		if (state_q == S_EXEC) begin
			rsp_q <= ex_rsp;
		end else if (state_q == S_SCAN && (hit || last_grp)) begin
			rsp_q <= scan_rsp;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

### hw/rtl/semb_chk.sv
module semb_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input semb_pkg::rsp_t rsp
);
	import semb_pkg::*;

	// result word comes out as the block goes idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");

	// an accepted word makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted word did not raise busy");

	// no two results back to back
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held longer than one cycle");

	// would-block reports a zero count and no wake
	a_block_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_BLOCK) |-> (rsp.count_after == 16'd0 && !rsp.wake))
		else $error("would-block with nonzero count or wake");

	// wake only on a successful step from zero to one
	a_wake_one: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.wake) |-> (rsp.status == ST_DONE && rsp.count_after == 16'd1))
		else $error("wake without a step from zero");

endmodule

bind counting_semaphore_bank_top semb_chk u_semb_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

### sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import semb_pkg::*;

	// Command codes that the bank leaves undefined
	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

	localparam int RANDOM_WORDS = 450;
	localparam int RUN_LIMIT    = 400000;
	localparam int SETTLE_CYCLES = 16;

	typedef struct {
		cmd_t        word;
		int unsigned idle_after;
		bit          wait_empty;
	} queued_word_t;

	typedef struct {
		cmd_t word;
		rsp_t rsp;
	} sem_outcome_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	cmd_t cmd    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	counting_semaphore_bank_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow of the bank: counts and open flags, updated as each word is taken
	cnt_t bank_count [NUM_SEMS];
	bit   bank_open  [NUM_SEMS];

	queued_word_t cmd_backlog[$];
	sem_outcome_t sem_results_due[$];

	int          words_in_flight = 0;
	int          words_sent      = 0;
	int unsigned idle_left       = 0;
	int          fail_count      = 0;
	int          cycle_count     = 0;
	int          n_done = 0, n_reject = 0, n_block = 0, n_wake = 0, n_found = 0;

	// Stimulus shaping
	bit calm      = 1'b0;
	bit hold_next = 1'b0;

	// Apply one command word to the shadow bank and return the result word it gives
	function automatic rsp_t sem_apply(cmd_t w);
		rsp_t   r;
		longint top;
		cnt_t   c;
		bit     found;
		r     = '0;
		top   = (longint'(1) << COUNT_BITS) - 1;
		found = 1'b0;
		if (w.command == CMD_FIND) begin
			r.status = ST_REJECT;
			for (int i = 0; i < NUM_SEMS; i++) begin
				if (!found && !bank_open[i]) begin
					found        = 1'b1;
					r.status     = ST_DONE;
					r.free_index = 4'(i);
				end
			end
			return r;
		end
		// Index beyond the bank: reject, touch nothing
		if (int'(w.sem_index) >= NUM_SEMS) begin
			r.status = ST_REJECT;
			return r;
		end
		c             = bank_count[w.sem_index];
		r.count_after = 16'(c);
		case (w.command)
			CMD_OPEN: begin
				if (bank_open[w.sem_index] || longint'(w.init_value) > top) begin
					r.status = ST_REJECT;
				end else begin
					bank_count[w.sem_index] = cnt_t'(w.init_value);
					bank_open[w.sem_index]  = 1'b1;
					r.status                = ST_DONE;
					r.count_after           = w.init_value;
				end
			end
			CMD_CLOSE: begin
				bank_open[w.sem_index] = 1'b0;
				r.status               = ST_DONE;
			end
			CMD_UP: begin
				// Saturate at the top count, no wake
				if (longint'(c) >= top) begin
					r.status = ST_REJECT;
				end else begin
					bank_count[w.sem_index] = c + 1'b1;
					r.status                = ST_DONE;
					r.wake                  = (c == '0);
					r.count_after           = 16'(c + 1'b1);
				end
			end
			CMD_DOWN: begin
				if (c == '0) begin
					r.status      = ST_BLOCK;
					r.count_after = '0;
				end else begin
					bank_count[w.sem_index] = c - 1'b1;
					r.status                = ST_DONE;
					r.count_after           = 16'(c - 1'b1);
				end
			end
			default: begin
				r.status = ST_REJECT;
			end
		endcase
		return r;
	endfunction

	// Idle cycles after a word: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(8, 40);
	endfunction

	// Starting counts lean toward the edges of the range
	function automatic logic [15:0] pick_count();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'hFFFE;
			3, 4: return 16'($urandom_range(0, 7));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_word(logic [2:0] code, logic [3:0] idx, logic [15:0] val);
		queued_word_t q;
		q.word.command    = code;
		q.word.sem_index  = idx;
		q.word.init_value = val;
		q.idle_after      = pick_gap();
		q.wait_empty      = hold_next;
		hold_next         = 1'b0;
		cmd_backlog.push_back(q);
	endtask

	task automatic add_random_word();
		int unsigned c;
		logic [2:0]  code;
		c    = $urandom_range(0, 15);
		code = (c < 13) ? 3'(c % 5) : 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
		add_word(code, 4'($urandom), 16'($urandom));
	endtask

	// Driver: hold a word until it is taken, then idle or advance to the next one
	always @(posedge clk) begin : drive
		bit           taken;
		sem_outcome_t due;
		queued_word_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				due.word = cmd;
				due.rsp  = sem_apply(cmd);
				sem_results_due.push_back(due);
				words_in_flight++;
				words_sent++;
			end
			if (done)
				words_in_flight--;
			if (!start || taken) begin
				if (idle_left != 0) begin
					idle_left--;
					start <= 1'b0;
				end else if (cmd_backlog.size() != 0 &&
						!(cmd_backlog[0].wait_empty && words_in_flight != 0)) begin
					nxt = cmd_backlog.pop_front();
					cmd       <= nxt.word;
					start     <= 1'b1;
					idle_left = nxt.idle_after;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed result word is checked against the oldest prediction
	always @(posedge clk) begin : check
		sem_outcome_t want;
		if (arst_n && done) begin
			if (sem_results_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("result word with nothing due: status=%0d wake=%0d count=%0d free=%0d",
						rsp.status, rsp.wake, rsp.count_after, rsp.free_index);
			end else begin
				want = sem_results_due.pop_front();
				if (rsp.status !== want.rsp.status || rsp.wake !== want.rsp.wake ||
						rsp.count_after !== want.rsp.count_after ||
						rsp.free_index !== want.rsp.free_index) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch cmd=%0d idx=%0d val=%0h: exp st=%0d wk=%0d cnt=%0h fi=%0d, got st=%0d wk=%0d cnt=%0h fi=%0d",
							want.word.command, want.word.sem_index, want.word.init_value,
							want.rsp.status, want.rsp.wake, want.rsp.count_after,
							want.rsp.free_index, rsp.status, rsp.wake, rsp.count_after,
							rsp.free_index);
				end
				case (want.rsp.status)
					ST_DONE:   n_done++;
					ST_BLOCK:  n_block++;
					default:   n_reject++;
				endcase
				if (want.rsp.wake)
					n_wake++;
				if (want.word.command == CMD_FIND && want.rsp.status == ST_DONE)
					n_found++;
			end
		end
	end

	// Watchdog: drop the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due", cycle_count,
				sem_results_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		int          order [NUM_SEMS];
		int          j;
		int          tmp;
		int          held;
		int unsigned kind;
		int unsigned k;
		logic [3:0]  idx;

		for (int i = 0; i < NUM_SEMS; i++) begin
			bank_count[i] = '0;
			bank_open[i]  = 1'b0;
		end

		// Directed: fresh bank, wake, double open, saturation, double close, spare codes
		calm = 1'b1;
		add_word(CMD_FIND,  4'd0,  16'h0000);  // everything closed, lowest is 0
		add_word(CMD_DOWN,  4'd0,  16'hFFFF);  // down at zero blocks
		add_word(CMD_UP,    4'd0,  16'h0000);  // up on a closed entry, wakes
		add_word(CMD_OPEN,  4'd0,  16'h0000);
		add_word(CMD_OPEN,  4'd0,  16'h1234);  // already open: reject
		add_word(CMD_OPEN,  4'd15, 16'hFFFF);
		add_word(CMD_UP,    4'd15, 16'h0000);  // at the top count: reject
		add_word(CMD_DOWN,  4'd15, 16'h0000);
		add_word(CMD_CLOSE, 4'd15, 16'h0000);
		add_word(CMD_CLOSE, 4'd15, 16'hFFFF);  // closing a closed entry keeps its count
		add_word(CMD_UP,    4'd15, 16'h0000);
		add_word(CMD_FIND,  4'd15, 16'hFFFF);
		add_word(CMD_SPARE_FIRST, 4'd15, 16'hFFFF);
		add_word(CMD_SPARE_FIRST + 3'd1, 4'd0, 16'h0000);
		add_word(CMD_SPARE_LAST,  4'd8,  16'h5A5A);
		add_word(CMD_DOWN,  4'd0,  16'h0000);
		add_word(CMD_UP,    4'd0,  16'h0000);

		// Random: mostly whole semaphore lifecycles, the rest loose words
		hold_next = 1'b1;
		k         = 0;
		while (k < RANDOM_WORDS) begin
			if (k > 240 && k < 260)
				hold_next = 1'b1;
			calm = ($urandom_range(0, 7) == 0);
			kind = $urandom_range(0, 9);
			idx  = 4'($urandom);
			j    = cmd_backlog.size();
			case (kind)
				0, 1, 2: begin
					add_random_word();
				end
				3, 4, 5: begin
					// Close, then open with a small count, raise, lower by two more steps than raised, close
					tmp = $urandom_range(1, 4);
					add_word(CMD_CLOSE, idx, 16'($urandom));
					add_word(CMD_OPEN, idx, 16'($urandom_range(0, 5)));
					for (int i = 0; i < tmp; i++)
						add_word(CMD_UP, idx, 16'($urandom));
					for (int i = 0; i <= tmp + 1; i++)
						add_word(CMD_DOWN, idx, 16'($urandom));
					add_word(CMD_CLOSE, idx, 16'($urandom));
				end
				6: begin
					// Run into saturation and back
					add_word(CMD_CLOSE, idx, 16'h0000);
					add_word(CMD_OPEN, idx, 16'hFFFF - 16'($urandom_range(0, 2)));
					for (int i = 0; i < 3; i++)
						add_word(CMD_UP, idx, 16'($urandom));
					add_word(CMD_DOWN, idx, 16'($urandom));
					add_word(CMD_UP, idx, 16'($urandom));
				end
				7: begin
					// Fill the bank in shuffled order so a free scan comes back empty
					for (int i = 0; i < NUM_SEMS; i++)
						order[i] = i;
					for (int i = NUM_SEMS - 1; i > 0; i--) begin
						tmp        = $urandom_range(0, i);
						held       = order[i];
						order[i]   = order[tmp];
						order[tmp] = held;
					end
					for (int i = 0; i < NUM_SEMS; i++)
						add_word(CMD_OPEN, 4'(order[i]), pick_count());
					add_word(CMD_FIND, idx, 16'($urandom));
					tmp = $urandom_range(1, 3);
					for (int i = 0; i < tmp; i++)
						add_word(CMD_CLOSE, 4'($urandom), 16'($urandom));
					add_word(CMD_FIND, 4'($urandom), 16'($urandom));
				end
				8: begin
					add_word(CMD_FIND, idx, 16'($urandom));
					add_word(CMD_CLOSE, idx, 16'($urandom));
					add_word(CMD_FIND, 4'($urandom), 16'($urandom));
				end
				default: begin
					// Noise: spare codes and stray downs
					add_word(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)), idx,
						16'($urandom));
					add_word(CMD_DOWN, 4'($urandom), 16'($urandom));
				end
			endcase
			j = cmd_backlog.size() - j;
			k = k + j;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the backlog to drain and every result word to come back
		while (cmd_backlog.size() != 0 || start || words_in_flight != 0 ||
				sem_results_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (sem_results_due.size() != 0) begin
			fail_count += sem_results_due.size();
			$display("%0d result words never arrived", sem_results_due.size());
		end

		$display("sent %0d command words: %0d done, %0d rejected, %0d would-block",
			words_sent, n_done, n_reject, n_block);
		$display("  %0d wakes, %0d free scans that found an entry, %0d failures",
			n_wake, n_found, fail_count);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
